// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the hasher rtl
// no dependencies; checks vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst, a, b)
`define CHK_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- hw/rtl/sha_pkg.sv -----
// shared types, constants and round functions for the hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_START = 56;

  // block handed from front to back: data, and whether it ends the message
  typedef struct packed {
    logic [511:0] data;
    logic         last;
  } blk_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher_core.sv -----
// SHA-256 stream hasher top level: byte front part, block register, round engine
// depends on sha_pkg, sha_front, sha_back and assert_macros.svh
//
// Usage: push one item per cycle (data_byte, has_byte, end_of_message) while
// full is low. Bytes are packed into 64-byte blocks in the front part; a
// finished block waits in a one-entry block register until the back part
// takes it. The back part handles a block as a load, 64 rounds and an add
// into the chaining value. full stays high while the block register is
// occupied, so no new bytes go in while a finished block waits. An end item
// adds padding (one or two more blocks, one front state each), then eight
// digest words appear on the result side, word 0 first, last_word high on
// word 7, one word per cycle while pop is high.
// A stalled receiver (pop low) holds the digest and backs up the front.
// Synchronous reset restores the initial hash and empties everything.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha256_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha_pkg::blk_t blk;
  logic          blk_valid;
  logic          blk_ready;
  logic          busy;

  // byte packer and padding
  sha_front u_front (
    .clk, .rst, .push, .full, .data_byte, .has_byte, .end_of_message,
    .blk_valid, .blk_ready, .blk
  );

  // compression rounds and digest
  sha_back u_back (
    .clk, .rst, .blk_valid, .blk_ready, .blk, .empty, .pop,
    .digest_word, .word_index, .last_word, .busy
  );

  `CHK_IMPLY(a_ready_idle, clk, rst, blk_ready, !busy)
  `CHK_IMPLY(a_out_busy, clk, rst, !empty, busy)
  `CHK_NEXT(a_last_done, clk, rst, !empty && pop && last_word, empty)

endmodule
`default_nettype wire

// ----- hw/rtl/sha_front.sv -----
// front part: packs bytes into blocks, adds padding and length
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    data_byte,
  input  wire logic          has_byte,
  input  wire logic          end_of_message,
  output logic               blk_valid,
  input  wire logic          blk_ready,
  output sha_pkg::blk_t      blk
);

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_PAD  = 3'b010,
    ST_LEN  = 3'b100
  } fst_t;

  fst_t         state;
  logic [511:0] buffer;
  logic [5:0]   fill_offset;
  logic [63:0]  bit_count;
  logic         out_full;

  // byte lane helper
  function automatic logic [511:0] put_byte(input logic [511:0] b, input logic [5:0] idx,
                                            input logic [7:0] v);
    logic [511:0] r;
    r = b;
    r[511 - 8 * idx -: 8] = v;
    put_byte = r;
  endfunction

  assign full = (state != ST_FILL) || out_full;
  assign blk_valid = out_full;

  // byte collection, padding and block hand-off
  always_ff @(posedge clk) begin
    logic [511:0] nb;
    logic [63:0]  nc;
    logic [6:0]   nf;
    logic         out_full_next;
    if (rst) begin
      state       <= ST_FILL;
      fill_offset <= '0;
      bit_count   <= '0;
      buffer      <= '0;
      out_full    <= 1'b0;
    end else begin
      out_full_next = out_full && !(blk_valid && blk_ready);
      if (!out_full || blk_ready) begin
        case (state)
          ST_FILL: begin
            if (push && !out_full) begin
              nb = buffer;
              nc = bit_count;
              nf = {1'b0, fill_offset};
              if (has_byte) begin
                nb = put_byte(nb, fill_offset, data_byte);
                nc = bit_count + 64'd8;
                nf = nf + 7'd1;
              end
              if (nf[6]) begin
                blk.data <= nb;
                blk.last <= 1'b0;
                out_full_next = 1'b1;
                nb = '0;
                nf = '0;
              end
              if (end_of_message) begin
                // pad byte goes in now; padding continues in ST_PAD or ST_LEN
                if (nf[6] == 1'b0 && !(has_byte && fill_offset == 6'd63)) begin
                  nb = put_byte(nb, nf[5:0], sha_pkg::PAD_BYTE);
                  state <= (nf[5:0] >= 6'(sha_pkg::LEN_START)) ? ST_PAD : ST_LEN;
                end else begin
                  nb = put_byte(nb, 6'd0, sha_pkg::PAD_BYTE);
                  state <= ST_LEN;
                end
              end
              buffer      <= nb;
              bit_count   <= nc;
              fill_offset <= nf[5:0];
            end
          end
          ST_PAD: begin
            blk.data <= buffer;
            blk.last <= 1'b0;
            out_full_next = 1'b1;
            buffer   <= '0;
            state    <= ST_LEN;
          end
          ST_LEN: begin
            blk.data    <= {buffer[511:64], bit_count};
            blk.last    <= 1'b1;
            out_full_next = 1'b1;
            buffer      <= '0;
            bit_count   <= '0;
            fill_offset <= '0;
            state       <= ST_FILL;
          end
          default: state <= ST_FILL;
        endcase
      end
      out_full <= out_full_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sha_back.sv -----
// back part: 64-round compression, one round per cycle, digest output
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          blk_valid,
  output logic               blk_ready,
  input  wire sha_pkg::blk_t blk,
  output logic               empty,
  input  wire logic          pop,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word,
  output logic               busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_EMIT = 4'b1000
  } bst_t;

  bst_t        state;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  round;
  logic        last;
  logic [2:0]  emit_idx;

  logic [31:0] wt, t1, t2, s0, s1;

  assign blk_ready = (state == ST_IDLE);
  assign busy = (state != ST_IDLE);
  assign empty = (state != ST_EMIT);
  assign digest_word = h[emit_idx];
  assign word_index = emit_idx;
  assign last_word = (emit_idx == 3'd7);

  // schedule word and round sums; w holds the window with w[0] oldest
  always_comb begin
    s0 = sha_pkg::rotr(w[1], 7) ^ sha_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = sha_pkg::rotr(w[14], 17) ^ sha_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wt = (round < 6'd16) ? w[0] : (s1 + w[9] + s0 + w[0]);
    t1 = v[7] + (sha_pkg::rotr(v[4], 6) ^ sha_pkg::rotr(v[4], 11) ^ sha_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[round] + wt;
    t2 = (sha_pkg::rotr(v[0], 2) ^ sha_pkg::rotr(v[0], 13) ^ sha_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // round sequencer and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      round    <= '0;
      emit_idx <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::INIT_H[i];
    end else begin
      case (state)
        ST_IDLE: begin
          if (blk_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= blk.data[511 - 32 * i -: 32];
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            last  <= blk.last;
            round <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= wt;
          v[0] <= t1 + t2;
          v[1] <= v[0];
          v[2] <= v[1];
          v[3] <= v[2];
          v[4] <= v[3] + t1;
          v[5] <= v[4];
          v[6] <= v[5];
          v[7] <= v[6];
          round <= round + 6'd1;
          if (round == 6'd63) state <= ST_ADD;
        end
        // fold the working variables into the chaining value
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          emit_idx <= '0;
          state <= last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (pop) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= sha_pkg::INIT_H[i];
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
